@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define SGB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/sgb_pkg.sv @@
`default_nettype none
package sgb_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int CH_W       = 20;
  localparam int RS_W       = 3 * CH_W;
  localparam int SUM_W      = 12;
  localparam int SQ_W       = 24;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEF_BITS  = 120;
  localparam int DBIT_W     = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFS_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFS_HIGH  = 3'd4;

  typedef struct packed {
    logic capture;
    logic latch;
    logic sum_step;
    logic square;
    logic start_row;
    logic start_drain;
    logic tap_clr;
    logic h_step;
    logic h_write;
    logic v_start;
    logic v_addr;
    logic v_mac;
    logic div_init;
    logic div_step;
    logic out_load;
    logic next_col;
    logic advance;
  } sgb_cmd_t;

  typedef struct packed {
    logic at_frame_start;
    logic in_image;
    logic kind;
    logic range_empty;
    logic drain_emit;
    logic can_emit;
    logic col_last;
    logic tap_last;
    logic sum_last;
    logic div_last;
    logic emit_last;
    logic out_free;
  } sgb_stat_t;

endpackage
`default_nettype wire

@@ rtl/sgb_in_if.sv @@
`default_nettype none
interface sgb_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

@@ rtl/sgb_out_if.sv @@
`default_nettype none
interface sgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_in_run;
  logic       end_of_frame;

  modport source (output valid, red_out, green_out, blue_out, last_in_run, end_of_frame,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, last_in_run, end_of_frame,
                output ready);
endinterface
`default_nettype wire

@@ rtl/separable_gaussian_blur.sv @@
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    kind, red_in, green_in, blue_in
// out_ch   out  valid/ready    red_out, green_out, blue_out, last_in_run, end_of_frame
// cfg      in   cfg_we         cfg_index, cfg_data
//
// One item at a time: a real pixel is captured, then finishes each row-sum column in its range and
// each result that it can emit; a drain item gives one result or none.
// The per-pass multiply-accumulates and the bit-serial divider set the time per item.
// The first item of a frame also latches the settings, sums the taps and squares the tap sum.
// Synchronous active-low reset; the line store has no reset and needs no clearing pass.
// A stalled output holds the sequencer; the next item is taken while the last result waits.
`default_nettype none
`include "assert_macros.svh"
module separable_gaussian_blur #(
  parameter int MAX_TAPS   = 15,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sgb_in_if.sink                         in_ch,
  sgb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data
);

  sgb_pkg::sgb_cmd_t  cmd;
  sgb_pkg::sgb_stat_t stat;

  sgb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sgb_dp #(
    .MAX_TAPS   (MAX_TAPS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (in_ch.kind),
    .in_red    (in_ch.red_in),
    .in_green  (in_ch.green_in),
    .in_blue   (in_ch.blue_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_red   (out_ch.red_out),
    .out_green (out_ch.green_out),
    .out_blue  (out_ch.blue_out),
    .out_last  (out_ch.last_in_run),
    .out_eof   (out_ch.end_of_frame)
  );

  `SGB_ASSERT(a_load_free, cmd.out_load |-> stat.out_free, "result loaded over a pending transfer")
  `SGB_ASSERT(a_one_item, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "second item taken early")
  `SGB_NEVER(a_mem_port, cmd.h_write && cmd.v_addr, "line store read and write collide")

endmodule
`default_nettype wire

@@ rtl/sgb_ctrl.sv @@
`default_nettype none
module sgb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgb_pkg::sgb_stat_t stat,
  output sgb_pkg::sgb_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUM    = 4'd1;
  localparam logic [3:0] S_SQR    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_HTAP   = 4'd4;
  localparam logic [3:0] S_HWR    = 4'd5;
  localparam logic [3:0] S_VADR   = 4'd6;
  localparam logic [3:0] S_VMAC   = 4'd7;
  localparam logic [3:0] S_DINIT  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_ADV    = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.at_frame_start) begin
            cmd.latch   = 1'b1;
            cmd.tap_clr = 1'b1;
            state_nxt   = S_SUM;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_last) begin
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.in_image) begin
          if (stat.kind) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.start_row = 1'b1;
            cmd.tap_clr   = 1'b1;
            state_nxt     = stat.range_empty ? S_ADV : S_HTAP;
          end
        end else if (stat.drain_emit) begin
          cmd.start_drain = 1'b1;
          cmd.tap_clr     = 1'b1;
          state_nxt       = S_VADR;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_HTAP: begin
        cmd.h_step = 1'b1;
        if (stat.tap_last) begin
          state_nxt = S_HWR;
        end
      end
      S_HWR: begin
        cmd.h_write = 1'b1;
        if (stat.can_emit) begin
          cmd.v_start = 1'b1;
          cmd.tap_clr = 1'b1;
          state_nxt   = S_VADR;
        end else if (stat.col_last) begin
          state_nxt = S_ADV;
        end else begin
          cmd.next_col = 1'b1;
          cmd.tap_clr  = 1'b1;
          state_nxt    = S_HTAP;
        end
      end
      S_VADR: begin
        cmd.v_addr = 1'b1;
        state_nxt  = S_VMAC;
      end
      S_VMAC: begin
        cmd.v_mac = 1'b1;
        state_nxt = stat.tap_last ? S_DINIT : S_VADR;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.emit_last) begin
            state_nxt = S_ADV;
          end else begin
            cmd.next_col = 1'b1;
            cmd.tap_clr  = 1'b1;
            state_nxt    = S_HTAP;
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/sgb_dp.sv @@
`default_nettype none
module sgb_dp #(
  parameter int MAX_TAPS   = 15,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  sgb_pkg::sgb_cmd_t                   cmd,
  output sgb_pkg::sgb_stat_t                  stat,
  input  logic                                in_kind,
  input  logic [sgb_pkg::PIX_W-1:0]           in_red,
  input  logic [sgb_pkg::PIX_W-1:0]           in_green,
  input  logic [sgb_pkg::PIX_W-1:0]           in_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sgb_pkg::PIX_W-1:0]           out_red,
  output logic [sgb_pkg::PIX_W-1:0]           out_green,
  output logic [sgb_pkg::PIX_W-1:0]           out_blue,
  output logic                                out_last,
  output logic                                out_eof
);

  localparam int TIW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TCW   = $clog2(MAX_TAPS + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + MAX_TAPS);
  localparam int DEPTH = MAX_TAPS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = XW + 3;
  localparam int VSW   = RW + 2;
  localparam int MW    = TIW + 2;
  localparam int PW    = 3 * sgb_pkg::PIX_W;

  // configuration registers
  logic [10:0] cfg_w_r, cfg_h_r;
  logic [3:0]  cfg_t_r;
  logic [63:0] cfg_cl_r;
  logic [55:0] cfg_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= 11'd640;
      cfg_h_r  <= 11'd480;
      cfg_t_r  <= 4'd5;
      cfg_cl_r <= '0;
      cfg_ch_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgb_pkg::REG_IMAGE_WIDTH:  cfg_w_r  <= cfg_data[10:0];
        sgb_pkg::REG_IMAGE_HEIGHT: cfg_h_r  <= cfg_data[10:0];
        sgb_pkg::REG_TAP_COUNT:    cfg_t_r  <= cfg_data[3:0];
        sgb_pkg::REG_COEFFS_LOW:   cfg_cl_r <= cfg_data;
        sgb_pkg::REG_COEFFS_HIGH:  cfg_ch_r <= cfg_data[55:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0]  w_cl;
  logic [HW-1:0]  h_cl;
  logic [TCW-1:0] t_cl;
  logic [sgb_pkg::COEF_BITS-1:0] coef_all;

  assign coef_all = {cfg_ch_r, cfg_cl_r};

  always_comb begin
    if (cfg_w_r == '0) begin
      w_cl = WW'(1);
    end else if (32'(cfg_w_r) > 32'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_cl = HW'(1);
    end else if (32'(cfg_h_r) > 32'(MAX_HEIGHT)) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(cfg_h_r);
    end
    if (cfg_t_r == '0) begin
      t_cl = TCW'(1);
    end else if (32'(cfg_t_r) > 32'(MAX_TAPS)) begin
      t_cl = TCW'(MAX_TAPS);
    end else begin
      t_cl = TCW'(cfg_t_r);
    end
  end

  // frame settings
  logic [WW-1:0]                 lat_w_r;
  logic [HW-1:0]                 lat_h_r;
  logic [TCW-1:0]                lat_t_r;
  logic [sgb_pkg::COEF_W-1:0]    coef_r [MAX_TAPS];
  logic [sgb_pkg::SUM_W-1:0]     sum_r;
  logic [sgb_pkg::SQ_W-1:0]      s2_r;
  logic [TCW-1:0]                half;
  logic [TCW-1:0]                tap_idx_r;
  logic [sgb_pkg::COEF_W-1:0]    cf;

  assign half = lat_t_r >> 1;
  assign cf   = coef_r[tap_idx_r[TIW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_w_r <= WW'(640);
      lat_h_r <= HW'(480);
      lat_t_r <= TCW'(5);
      sum_r   <= '0;
      s2_r    <= '0;
    end else begin
      if (cmd.latch) begin
        lat_w_r <= w_cl;
        lat_h_r <= h_cl;
        lat_t_r <= t_cl;
        sum_r   <= '0;
      end else if (cmd.sum_step && tap_idx_r < lat_t_r) begin
        sum_r <= sum_r + sgb_pkg::SUM_W'(cf);
      end
      if (cmd.square) begin
        s2_r <= sgb_pkg::SQ_W'(sum_r) * sgb_pkg::SQ_W'(sum_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef_r[i] <= coef_all[i*sgb_pkg::COEF_W +: sgb_pkg::COEF_W];
      end
    end
  end

  // position counters
  logic [XW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [TIW-1:0] rmod_r;
  logic           row_end;
  logic           eof_seen_r;

  assign row_end = (32'(col_r) + 1) >= 32'(lat_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      rmod_r <= '0;
    end else if (cmd.advance) begin
      if (eof_seen_r) begin
        col_r  <= '0;
        row_r  <= '0;
        rmod_r <= '0;
      end else if (row_end) begin
        col_r  <= '0;
        row_r  <= row_r + RW'(1);
        rmod_r <= (32'(rmod_r) == MAX_TAPS - 1) ? '0 : rmod_r + TIW'(1);
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  // input capture and row window
  logic [PW-1:0] pix_r;
  logic          kind_r;
  logic [PW-1:0] win_r [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r  <= {in_red, in_green, in_blue};
      kind_r <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.start_row) begin
      win_r[0] <= pix_r;
      for (int i = 1; i < MAX_TAPS; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // horizontal pass
  logic [XW-1:0] c_r, hi_r, lo, hi;
  logic          p_ge_half;
  logic [SW-1:0] ha, hk;
  logic          h_ok;
  logic [PW-1:0] wpix;
  logic [sgb_pkg::CH_W-1:0] hacc_r [3];

  assign p_ge_half = 32'(col_r) >= 32'(half);
  assign lo        = p_ge_half ? col_r - XW'(half) : '0;
  assign hi        = row_end ? col_r : col_r - XW'(half);
  assign ha        = SW'(c_r) + SW'(tap_idx_r) - SW'(half);
  assign hk        = SW'(col_r) - ha;
  assign h_ok      = !ha[SW-1] && (ha < SW'(lat_w_r)) && !hk[SW-1] && (hk < SW'(MAX_TAPS));
  assign wpix      = win_r[hk[TIW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.start_row) begin
      c_r  <= lo;
      hi_r <= hi;
    end else if (cmd.next_col) begin
      c_r <= c_r + XW'(1);
    end
  end

  // vertical pass addressing
  logic [VSW-1:0] va;
  logic           v_ok;
  logic [MW-1:0]  vm_s;
  logic [TIW-1:0] vrow;
  logic [XW-1:0]  ec_r, em_col;
  logic [AW-1:0]  waddr, raddr;

  assign va   = VSW'(row_r) + VSW'(tap_idx_r) - VSW'(half) - VSW'(half);
  assign v_ok = !va[VSW-1] && (va < VSW'(lat_h_r));
  assign vm_s = MW'(rmod_r) + MW'(tap_idx_r) - MW'(half) - MW'(half);

  always_comb begin
    if (vm_s[MW-1]) begin
      vrow = TIW'(vm_s + MW'(MAX_TAPS));
    end else if (vm_s >= MW'(MAX_TAPS)) begin
      vrow = TIW'(vm_s - MW'(MAX_TAPS));
    end else begin
      vrow = TIW'(vm_s);
    end
  end

  assign waddr  = AW'(rmod_r) * AW'(MAX_WIDTH) + AW'(c_r);
  assign raddr  = AW'(vrow) * AW'(MAX_WIDTH) + AW'(ec_r);
  assign em_col = cmd.start_drain ? col_r : c_r;

  // row sum line store
  logic [sgb_pkg::RS_W-1:0]   mem_r [DEPTH];
  logic [sgb_pkg::RS_W-1:0]   rd_r;
  logic                       v_ok_r;
  logic [sgb_pkg::COEF_W-1:0] vcf_r;

  always_ff @(posedge clk) begin
    if (cmd.h_write) begin
      mem_r[waddr] <= {hacc_r[2], hacc_r[1], hacc_r[0]};
    end
    if (cmd.v_addr) begin
      rd_r   <= mem_r[raddr];
      v_ok_r <= v_ok;
      vcf_r  <= cf;
    end
  end

  // tap counter shared by the tap sum and both passes, with a multiply-accumulate per pass
  logic [sgb_pkg::ACC_W-1:0] vacc_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_idx_r <= '0;
    end else if (cmd.tap_clr) begin
      tap_idx_r <= '0;
    end else if (cmd.sum_step || cmd.h_step || cmd.v_mac) begin
      tap_idx_r <= tap_idx_r + TCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.tap_clr) begin
        hacc_r[ch] <= '0;
        vacc_r[ch] <= '0;
      end else begin
        if (cmd.h_step && h_ok) begin
          hacc_r[ch] <= hacc_r[ch] + sgb_pkg::CH_W'(cf)
                        * sgb_pkg::CH_W'(wpix[(2-ch)*sgb_pkg::PIX_W +: sgb_pkg::PIX_W]);
        end
        if (cmd.v_mac && v_ok_r) begin
          vacc_r[ch] <= vacc_r[ch] + sgb_pkg::ACC_W'(vcf_r)
                        * sgb_pkg::ACC_W'(rd_r[ch*sgb_pkg::CH_W +: sgb_pkg::CH_W]);
        end
      end
    end
  end

  // emitted pixel flags
  logic ec_last_r, eof_r;

  always_ff @(posedge clk) begin
    if (cmd.v_start || cmd.start_drain) begin
      ec_r      <= em_col;
      ec_last_r <= cmd.start_drain || (c_r == hi_r);
      eof_r     <= ((32'(row_r) - 32'(half)) == (32'(lat_h_r) - 1))
                && (32'(em_col) == (32'(lat_w_r) - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eof_seen_r <= 1'b0;
    end else if (cmd.capture) begin
      eof_seen_r <= 1'b0;
    end else if (cmd.out_load && eof_r) begin
      eof_seen_r <= 1'b1;
    end
  end

  // restoring divide by the squared coefficient sum, one quotient bit a cycle
  logic [sgb_pkg::ACC_W-1:0]  rem_r [3];
  logic [sgb_pkg::PIX_W-1:0]  q_r [3];
  logic [2:0]                 ovf_r;
  logic [sgb_pkg::DBIT_W-1:0] dbit_r;
  logic [sgb_pkg::ACC_W-1:0]  dsh;
  logic [sgb_pkg::PIX_W-1:0]  res [3];

  assign dsh = sgb_pkg::ACC_W'(s2_r) << dbit_r;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dbit_r <= sgb_pkg::DBIT_W'(sgb_pkg::PIX_W - 1);
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch] <= vacc_r[ch];
        q_r[ch]   <= '0;
        ovf_r[ch] <= vacc_r[ch] >= {s2_r, 8'h00};
      end
    end else if (cmd.div_step) begin
      dbit_r <= dbit_r - sgb_pkg::DBIT_W'(1);
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= dsh) begin
          rem_r[ch]       <= rem_r[ch] - dsh;
          q_r[ch][dbit_r] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (s2_r == '0) begin
        res[ch] = '0;
      end else if (ovf_r[ch]) begin
        res[ch] = sgb_pkg::PIX_MAX;
      end else begin
        res[ch] = q_r[ch];
      end
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red   <= res[0];
      out_green <= res[1];
      out_blue  <= res[2];
      out_last  <= ec_last_r;
      out_eof   <= eof_r;
    end
  end

  assign out_valid = out_valid_r;

  // status
  assign stat.at_frame_start = (row_r == '0) && (col_r == '0);
  assign stat.in_image       = 32'(row_r) < 32'(lat_h_r);
  assign stat.kind           = kind_r;
  assign stat.range_empty    = !row_end && !p_ge_half;
  assign stat.can_emit       = 32'(row_r) >= 32'(half);
  assign stat.drain_emit     = stat.can_emit && ((32'(row_r) - 32'(half)) < 32'(lat_h_r));
  assign stat.col_last       = c_r == hi_r;
  assign stat.tap_last       = tap_idx_r == (lat_t_r - TCW'(1));
  assign stat.sum_last       = 32'(tap_idx_r) == (MAX_TAPS - 1);
  assign stat.div_last       = dbit_r == '0;
  assign stat.emit_last      = ec_last_r;
  assign stat.out_free       = !out_valid_r || out_ready;

endmodule
`default_nettype wire

@@ dv/sgb_blur_checker.sv @@
`timescale 1ns / 1ps
module sgb_blur_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  sgb_in_if                              in_ch,
  sgb_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);

  localparam int TAPS = 15;
  localparam int WMAX = 1024;
  localparam int HMAX = 1024;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       eof;
  } blur_px_t;

  logic [10:0] reg_w, reg_h;
  logic [3:0]  reg_taps;
  logic [63:0] reg_lo;
  logic [55:0] reg_hi;

  int unsigned lat_w, lat_h, lat_taps, tap_sum;
  int unsigned coef [TAPS];
  logic [23:0] window [TAPS];
  logic [59:0] line_sums [TAPS*WMAX];
  int col, row;
  logic frame_done;

  blur_px_t expected_px[$];
  blur_px_t step_px[$];

  function automatic int unsigned size_of(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void latch_settings();
    lat_w = size_of(reg_w, WMAX);
    lat_h = size_of(reg_h, HMAX);
    lat_taps = size_of(reg_taps, TAPS);
    tap_sum = 0;
    for (int i = 0; i < TAPS; i++) begin
      coef[i] = (i < 8) ? reg_lo[8*i +: 8] : reg_hi[8*(i-8) +: 8];
      if (i < lat_taps) tap_sum += coef[i];
    end
  endfunction

  function logic [59:0] row_total(int c, int p);
    logic [31:0] acc [3];
    int half, a, k;
    half = lat_taps / 2;
    for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
    for (int i = 0; i < lat_taps; i++) begin
      a = c + i - half;
      k = p - a;
      if (a < 0 || a >= lat_w || k < 0 || k >= TAPS) continue;
      for (int ch = 0; ch < 3; ch++)
        acc[ch] += coef[i] * window[k][16 - 8*ch +: 8];
    end
    return {acc[2][19:0], acc[1][19:0], acc[0][19:0]};
  endfunction

  function void emit_px(int r, int c);
    logic [63:0] acc [3];
    logic [63:0] s2, q;
    logic [59:0] v;
    logic [7:0] res [3];
    int half, a;
    blur_px_t e;
    half = lat_taps / 2;
    s2 = 64'(tap_sum) * 64'(tap_sum);
    for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
    for (int i = 0; i < lat_taps; i++) begin
      a = r + i - half;
      if (a < 0 || a >= lat_h || c < 0 || c >= WMAX) continue;
      v = line_sums[(a % TAPS) * WMAX + c];
      for (int ch = 0; ch < 3; ch++)
        acc[ch] += 64'(coef[i]) * 64'(v[20*ch +: 20]);
    end
    for (int ch = 0; ch < 3; ch++) begin
      q = (s2 != 0) ? acc[ch] / s2 : 64'd0;
      res[ch] = (q > 255) ? sgb_pkg::PIX_MAX : q[7:0];
    end
    e.red = res[0];
    e.green = res[1];
    e.blue = res[2];
    e.last = 1'b0;
    e.eof = (r == lat_h - 1 && c == lat_w - 1);
    if (e.eof) frame_done = 1'b1;
    step_px.push_back(e);
  endfunction

  function void predict_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int half, p, cur, lo, hi;
    if (row == 0 && col == 0) latch_settings();
    half = lat_taps / 2;
    p = col;
    cur = row;
    frame_done = 1'b0;
    step_px = {};
    if (row < lat_h) begin
      if (kind) return;
      for (int k = TAPS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = {r, g, b};
      lo = p - half;
      hi = (p + 1 >= lat_w) ? p : p - half;
      if (lo < 0) lo = 0;
      for (int c = lo; c <= hi && c < WMAX; c++) begin
        line_sums[(cur % TAPS) * WMAX + c] = row_total(c, p);
        if (cur >= half) emit_px(cur - half, c);
      end
    end else if (cur - half >= 0 && cur - half < lat_h) begin
      emit_px(cur - half, p);
    end
    if (step_px.size() > 0) step_px[step_px.size()-1].last = 1'b1;
    foreach (step_px[i]) expected_px.push_back(step_px[i]);
    if (frame_done) begin
      col = 0;
      row = 0;
    end else if (col + 1 >= lat_w) begin
      col = 0;
      row++;
    end else begin
      col++;
    end
  endfunction

  always @(posedge clk) begin
    blur_px_t got, want;
    if (!rst_n) begin
      fail_count = 0;
      reg_w = 11'd640;
      reg_h = 11'd480;
      reg_taps = 4'd5;
      reg_lo = '0;
      reg_hi = '0;
      col = 0;
      row = 0;
      for (int k = 0; k < TAPS; k++) window[k] = '0;
      latch_settings();
      tap_sum = 0;
      expected_px = {};
      pending <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.red_out, out_ch.green_out, out_ch.blue_out,
               out_ch.last_in_run, out_ch.end_of_frame};
        if (expected_px.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_px.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch rgb/last/eof expected %h %h %h %b %b actual %h %h %h %b %b",
                     $time, want.red, want.green, want.blue, want.last, want.eof,
                     got.red, got.green, got.blue, got.last, got.eof);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.kind, in_ch.red_in, in_ch.green_in, in_ch.blue_in);
      if (cfg_we) begin
        case (cfg_index)
          sgb_pkg::REG_IMAGE_WIDTH:  reg_w = cfg_data[10:0];
          sgb_pkg::REG_IMAGE_HEIGHT: reg_h = cfg_data[10:0];
          sgb_pkg::REG_TAP_COUNT:    reg_taps = cfg_data[3:0];
          sgb_pkg::REG_COEFFS_LOW:   reg_lo = cfg_data;
          sgb_pkg::REG_COEFFS_HIGH:  reg_hi = cfg_data[55:0];
          default: ;
        endcase
      end
      pending <= expected_px.size();
    end
  end
endmodule

@@ dv/tb_separable_gaussian_blur.sv @@
`timescale 1ns / 1ps
module tb_separable_gaussian_blur;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 600;

  logic clk, rst_n;
  logic cfg_we;
  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;
  int items_sent, idle_cycles;
  logic quiet;

  sgb_in_if  in_if();
  sgb_out_if out_if();

  separable_gaussian_blur u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sgb_blur_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  always begin
    @(negedge clk);
    if (quiet || $urandom_range(0, 4) != 0)
      out_if.ready <= 1'b1;
    else begin
      out_if.ready <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  end

  function automatic int unsigned eff(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [sgb_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
    if (!quiet && $urandom_range(0, 60) == 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      drain_results();
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.red_in <= r;
    in_if.green_in <= g;
    in_if.blue_in <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, int unsigned taps,
                           logic [63:0] lo, logic [55:0] hi);
    int unsigned ew, eh, half;
    write_reg(sgb_pkg::REG_IMAGE_WIDTH, 64'(w));
    write_reg(sgb_pkg::REG_IMAGE_HEIGHT, 64'(h));
    write_reg(sgb_pkg::REG_TAP_COUNT, 64'(taps));
    write_reg(sgb_pkg::REG_COEFFS_LOW, lo);
    write_reg(sgb_pkg::REG_COEFFS_HIGH, 64'(hi));
    ew = eff(w, 1024);
    eh = eff(h, 1024);
    half = eff(taps, 15) / 2;
    for (int i = 0; i < ew * eh; i++) begin
      if ($urandom_range(0, 11) == 0)
        send(1'b1, pick_color(), pick_color(), pick_color());
      send(1'b0, pick_color(), pick_color(), pick_color());
      items_sent++;
    end
    for (int i = 0; i < ew * half; i++) begin
      send($urandom_range(0, 3) != 0, pick_color(), pick_color(), pick_color());
      items_sent++;
    end
    @(negedge clk);
    in_if.valid <= 1'b0;
    drain_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.red_in = '0;
    in_if.green_in = '0;
    in_if.blue_in = '0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_frame(3, 2, 3, 64'hFF_FFFF, 56'h0);
    run_frame(4, 3, 5, 64'h0, 56'h0);
    run_frame(0, 0, 0, 64'h01, 56'h0);
    run_frame(2, 2, 15, {$urandom, $urandom}, 56'hFF_FFFF_FFFF_FFFF);
    run_frame(2, 3, 15, 64'hFFFF_FFFF_FFFF_FFFF, 56'h0);
    run_frame(9, 1, 1, 64'h80, 56'h0);
    run_frame(1, 9, 15, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF);

    while (items_sent < 300) begin
      if (items_sent > 260) quiet = 1'b1;
      run_frame($urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(0, 15),
                {$urandom, $urandom}, 56'({$urandom, $urandom}));
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
